// File: rtl/core/single_wire_humidity_sensor_reader_unit_defines.svh
// Assertion macros for the single-wire humidity sensor reader.
// Included by the modules that carry concurrent checks; expects a clk and rst in scope.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SWH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SWH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swh_pkg.sv
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; imported by every module of the block.
package swh_pkg;

  // Number of sensor lines and data pulses per read (first pulse is dropped)
  localparam int NUM_LINES = 8;
  localparam logic [5:0] PULSE_COUNT = 6'd41;

  // Read phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_WAIT_IDLE = 4'd1;
  localparam logic [3:0] PH_DRIVE     = 4'd2;
  localparam logic [3:0] PH_RESPONSE  = 4'd3;
  localparam logic [3:0] PH_ACK       = 4'd4;
  localparam logic [3:0] PH_SYNC      = 4'd5;
  localparam logic [3:0] PH_PULSE     = 4'd6;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HUNG   = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_ACK    = 3'd3;
  localparam logic [2:0] ST_SYNC   = 3'd4;
  localparam logic [2:0] ST_DATA   = 3'd5;
  localparam logic [2:0] ST_CSUM   = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_BIT_THRESHOLD     = 3'd0;
  localparam logic [2:0] REG_START_PULSE_TICKS = 3'd1;
  localparam logic [2:0] REG_IDLE_TIMEOUT      = 3'd2;
  localparam logic [2:0] REG_RESPONSE_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_ACK_TIMEOUT       = 3'd4;
  localparam logic [2:0] REG_SYNC_TIMEOUT      = 3'd5;
  localparam logic [2:0] REG_PULSE_TIMEOUT     = 3'd6;

  typedef struct packed {
    logic [7:0] bit_threshold;
    logic [9:0] start_pulse_ticks;
    logic [7:0] idle_timeout;
    logic [7:0] response_timeout;
    logic [7:0] ack_timeout;
    logic [7:0] sync_timeout;
    logic [7:0] pulse_timeout;
  } swh_cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic [2:0]        drive_line;
    logic              busy_res;
    logic              done_res;
    logic [2:0]        status;
    logic signed [15:0] temperature;
    logic [14:0]       humidity;
  } swh_result_t;

endpackage

// File: rtl/core/swh_cfg.sv
// Configuration register file of the humidity sensor reader.
// Depends on swh_pkg for the register indexes and the swh_cfg_t bundle.
module swh_cfg
  import swh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  output swh_cfg_t   cfg
);

  // Load the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_threshold     <= 8'd11;
      cfg.start_pulse_ticks <= 10'd550;
      cfg.idle_timeout      <= 8'd125;
      cfg.response_timeout  <= 8'd25;
      cfg.ack_timeout       <= 8'd50;
      cfg.sync_timeout      <= 8'd35;
      cfg.pulse_timeout     <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_THRESHOLD:     cfg.bit_threshold     <= cfg_data[7:0];
        REG_START_PULSE_TICKS: cfg.start_pulse_ticks <= cfg_data;
        REG_IDLE_TIMEOUT:      cfg.idle_timeout      <= cfg_data[7:0];
        REG_RESPONSE_TIMEOUT:  cfg.response_timeout  <= cfg_data[7:0];
        REG_ACK_TIMEOUT:       cfg.ack_timeout       <= cfg_data[7:0];
        REG_SYNC_TIMEOUT:      cfg.sync_timeout      <= cfg_data[7:0];
        REG_PULSE_TIMEOUT:     cfg.pulse_timeout     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/swh_core.sv
// Per-tick read sequencer: phase, tick counter, pulse counter and data shift register.
// Depends on swh_pkg and the assertion macros in the block's defines header.
`include "single_wire_humidity_sensor_reader_unit_defines.svh"

module swh_core
  import swh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  swh_cfg_t    cfg,
  input  logic        start_req,
  input  logic [2:0]  line_select,
  input  logic [7:0]  line_levels,
  output swh_result_t res
);

  logic [3:0]  phase, phase_next;
  logic [9:0]  tick_count, tick_next;
  logic [5:0]  pulse_index, pidx_next;
  logic [39:0] data_bits, data_next;
  logic [2:0]  active_line, line_next;

  logic        level;
  logic [9:0]  tick_inc;
  logic [9:0]  plen;
  logic [2:0]  sel_mod;
  logic        is_wait;
  logic [7:0]  wait_limit;
  logic        want;
  logic [2:0]  err_code;
  logic        finish;
  logic        ok_end;
  logic [15:0] hraw, traw;
  logic [7:0]  csum;

  // Wrap the line select onto the lines present
  always_comb begin
    sel_mod = '0;
    for (int k = 0; k < 8; k++) begin
      if (line_select == 3'(k)) sel_mod = 3'(k % NUM_LINES);
    end
  end

  // Pick the limit, awaited level and error code of the current wait phase
  always_comb begin
    is_wait    = 1'b1;
    wait_limit = '0;
    want       = 1'b1;
    err_code   = ST_OK;
    case (phase)
      PH_WAIT_IDLE: begin
        wait_limit = cfg.idle_timeout;
        err_code   = ST_HUNG;
      end
      PH_RESPONSE: begin
        wait_limit = cfg.response_timeout;
        err_code   = ST_ABSENT;
      end
      PH_ACK: begin
        wait_limit = cfg.ack_timeout;
        want       = 1'b0;
        err_code   = ST_ACK;
      end
      PH_SYNC: begin
        wait_limit = cfg.sync_timeout;
        err_code   = ST_SYNC;
      end
      PH_PULSE: begin
        wait_limit = cfg.pulse_timeout;
        want       = 1'b0;
        err_code   = ST_DATA;
      end
      default: is_wait = 1'b0;
    endcase
  end

  // Next state for one tick
  always_comb begin
    level       = line_levels[active_line];
    tick_inc    = tick_count + 10'd1;
    plen        = (cfg.start_pulse_ticks == '0) ? 10'd1 : cfg.start_pulse_ticks;
    phase_next  = phase;
    tick_next   = tick_count;
    pidx_next   = pulse_index;
    data_next   = data_bits;
    line_next   = active_line;
    finish      = 1'b0;
    ok_end      = 1'b0;

    if (is_wait) begin
      if (tick_count > {2'b00, wait_limit}) begin
        finish = 1'b1;
      end else begin
        tick_next = tick_inc;
        if (level == want) begin
          tick_next = '0;
          case (phase)
            PH_WAIT_IDLE: phase_next = PH_DRIVE;
            PH_RESPONSE:  phase_next = PH_ACK;
            PH_ACK:       phase_next = PH_SYNC;
            PH_SYNC:      phase_next = PH_PULSE;
            PH_PULSE: begin
              // Drop the first pulse, threshold the rest into data bits
              if (pulse_index != '0) begin
                data_next = {data_bits[38:0], (tick_inc > {2'b00, cfg.bit_threshold})};
              end
              pidx_next = pulse_index + 6'd1;
              if (pidx_next >= PULSE_COUNT) begin
                finish = 1'b1;
                ok_end = 1'b1;
              end else begin
                phase_next = PH_SYNC;
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (start_req) begin
            line_next  = sel_mod;
            phase_next = PH_WAIT_IDLE;
            tick_next  = '0;
            pidx_next  = '0;
            data_next  = '0;
          end
        end
        PH_DRIVE: begin
          tick_next = tick_inc;
          if (tick_inc >= plen) begin
            phase_next = PH_RESPONSE;
            tick_next  = '0;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          tick_next  = '0;
        end
      endcase
    end

    if (finish) begin
      phase_next = PH_IDLE;
      tick_next  = '0;
    end
  end

  // Decode the finished frame: humidity, sign-magnitude temperature, checksum
  always_comb begin
    hraw = data_next[39:24];
    traw = data_next[23:8];
    csum = hraw[15:8] + hraw[7:0] + traw[15:8] + traw[7:0];

    res.drive_low   = (phase_next == PH_DRIVE);
    res.drive_line  = line_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = finish;
    res.status      = ST_OK;
    res.temperature = '0;
    res.humidity    = '0;
    if (ok_end) begin
      res.status      = (csum == data_next[7:0]) ? ST_OK : ST_CSUM;
      res.humidity    = hraw[14:0];
      res.temperature = traw[15] ? $signed(16'd0 - {1'b0, traw[14:0]})
                                 : $signed({1'b0, traw[14:0]});
    end else if (finish) begin
      res.status = err_code;
    end
  end

  // Advance state only when a word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      pulse_index <= '0;
      data_bits   <= '0;
      active_line <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      tick_count  <= tick_next;
      pulse_index <= pidx_next;
      data_bits   <= data_next;
      active_line <= line_next;
    end
  end

  `SWH_ASSERT_NEXT(a_start_enters_wait,
    step_en && phase == PH_IDLE && start_req, phase == PH_WAIT_IDLE,
    "start request in idle did not begin a read")
  `SWH_ASSERT_NEXT(a_hold_without_step,
    !step_en, $stable(phase) && $stable(tick_count) && $stable(pulse_index),
    "sequencer state moved without a word")
  `SWH_ASSERT_NEXT(a_done_returns_idle,
    step_en && res.done_res, phase == PH_IDLE && tick_count == '0,
    "finished read did not return to idle")

endmodule

// File: rtl/core/swh_out_reg.sv
// Result register of the humidity sensor reader, with valid/stall toward the sink.
// Depends on swh_pkg for swh_result_t.
module swh_out_reg
  import swh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  swh_result_t res_in,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output swh_result_t res_out
);

  logic out_valid_next;

  // Free when empty or when the held word leaves this cycle
  assign ready = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (ready) out_valid_next = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Capture payload with the word
  always_ff @(posedge clk) begin
    if (load && ready) begin
      res_out <= res_in;
    end
  end

endmodule

// File: rtl/core/single_wire_humidity_sensor_reader_unit.sv
// Host-side reader for a single-wire temperature and humidity sensor. Each input word is
// one 2 us tick (start request, line select, sampled line levels) and yields exactly one
// result word: line drive, busy, done, status and, on the done tick, humidity and
// signed temperature. One word is accepted every clock cycle unless the result channel is
// stalled; a word's result is loaded into the result register when the sequencer steps on
// it. The word passes through the input register and the result register, with the
// sequencer's state update done in the single step between them. The user must see that
// configuration registers are written through a plain write port only while no read is busy;
// the block itself does not enforce it. Depends on swh_pkg, swh_cfg, swh_core and swh_out_reg.
module single_wire_humidity_sensor_reader_unit
  import swh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               start_req,
  input  logic [2:0]         line_select,
  input  logic [7:0]         line_levels,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               drive_low,
  output logic [2:0]         drive_line,
  output logic               busy_res,
  output logic               done_res,
  output logic [2:0]         status,
  output logic signed [15:0] temperature,
  output logic [14:0]        humidity,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  swh_cfg_t    cfg;
  swh_result_t step_res;
  swh_result_t res_q;

  logic       s1_valid, s1_valid_next;
  logic       s1_start;
  logic [2:0] s1_select;
  logic [7:0] s1_levels;
  logic       out_ready;
  logic       step_en;

  swh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Step the sequencer when a held word can move into the result register
  assign step_en  = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (!in_stall) s1_valid_next = in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start  <= start_req;
      s1_select <= line_select;
      s1_levels <= line_levels;
    end
  end

  swh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step_en),
    .cfg         (cfg),
    .start_req   (s1_start),
    .line_select (s1_select),
    .line_levels (s1_levels),
    .res         (step_res)
  );

  swh_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step_en),
    .res_in    (step_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign drive_low   = res_q.drive_low;
  assign drive_line  = res_q.drive_line;
  assign busy_res    = res_q.busy_res;
  assign done_res    = res_q.done_res;
  assign status      = res_q.status;
  assign temperature = res_q.temperature;
  assign humidity    = res_q.humidity;

endmodule

// File: sim/tb_single_wire_humidity_sensor_reader_unit.sv
// Self-checking testbench for the single-wire humidity sensor reader.
// A predictor class tracks every accepted tick word and checks each result word in order;
// depends on swh_pkg and single_wire_humidity_sensor_reader_unit.
`timescale 1ns / 1ps

module tb_single_wire_humidity_sensor_reader_unit;
  import swh_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int NEVER_TICKS = 4000;

  typedef enum logic [1:0] {WAIT_HOLD, WAIT_SEEN, WAIT_EXPIRED} wait_result_t;

  // Predicts one result word per tick word and checks the words that come back
  class read_result_board;
    swh_cfg_t    cfg;
    logic [3:0]  phase;
    logic [9:0]  tick_cnt;
    logic [5:0]  pulse_no;
    logic [39:0] frame;
    logic [2:0]  line;
    swh_result_t expected_results[$];
    int          errors;
    int          checked;

    function new();
      cfg.bit_threshold     = 8'd11;
      cfg.start_pulse_ticks = 10'd550;
      cfg.idle_timeout      = 8'd125;
      cfg.response_timeout  = 8'd25;
      cfg.ack_timeout       = 8'd50;
      cfg.sync_timeout      = 8'd35;
      cfg.pulse_timeout     = 8'd50;
      phase    = PH_IDLE;
      tick_cnt = '0;
      pulse_no = '0;
      frame    = '0;
      line     = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [9:0] val);
      case (idx)
        REG_BIT_THRESHOLD:     cfg.bit_threshold     = val[7:0];
        REG_START_PULSE_TICKS: cfg.start_pulse_ticks = val;
        REG_IDLE_TIMEOUT:      cfg.idle_timeout      = val[7:0];
        REG_RESPONSE_TIMEOUT:  cfg.response_timeout  = val[7:0];
        REG_ACK_TIMEOUT:       cfg.ack_timeout       = val[7:0];
        REG_SYNC_TIMEOUT:      cfg.sync_timeout      = val[7:0];
        REG_PULSE_TIMEOUT:     cfg.pulse_timeout     = val[7:0];
        default: ;
      endcase
    endfunction

    function void enter(logic [3:0] p);
      phase    = p;
      tick_cnt = '0;
    endfunction

    // Time out once the count is past the limit, else count and look for the level
    function wait_result_t await_level(logic [7:0] limit, logic lvl, logic want);
      if (tick_cnt > 10'(limit)) return WAIT_EXPIRED;
      tick_cnt = tick_cnt + 10'd1;
      return (lvl == want) ? WAIT_SEEN : WAIT_HOLD;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the sequencer by one accepted tick word and queue its result word
    function void note_tick(logic go, logic [2:0] sel, logic [7:0] levels);
      swh_result_t  r;
      wait_result_t w;
      logic         lvl;
      logic [9:0]   span;
      logic [2:0]   err;
      logic         failed;
      logic         complete;
      logic [15:0]  hraw;
      logic [15:0]  traw;
      logic [7:0]   sum;
      lvl      = levels[line];
      err      = ST_OK;
      failed   = 1'b0;
      complete = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (go) begin
            line     = sel;
            enter(PH_WAIT_IDLE);
            pulse_no = '0;
            frame    = '0;
          end
        end
        PH_WAIT_IDLE: begin
          w = await_level(cfg.idle_timeout, lvl, 1'b1);
          if (w == WAIT_EXPIRED) begin
            failed = 1'b1;
            err    = ST_HUNG;
          end else if (w == WAIT_SEEN) enter(PH_DRIVE);
        end
        PH_DRIVE: begin
          tick_cnt = tick_cnt + 10'd1;
          // a zero length still drives for one tick
          span = (cfg.start_pulse_ticks == '0) ? 10'd1 : cfg.start_pulse_ticks;
          if (tick_cnt >= span) enter(PH_RESPONSE);
        end
        PH_RESPONSE: begin
          w = await_level(cfg.response_timeout, lvl, 1'b1);
          if (w == WAIT_EXPIRED) begin
            failed = 1'b1;
            err    = ST_ABSENT;
          end else if (w == WAIT_SEEN) enter(PH_ACK);
        end
        PH_ACK: begin
          w = await_level(cfg.ack_timeout, lvl, 1'b0);
          if (w == WAIT_EXPIRED) begin
            failed = 1'b1;
            err    = ST_ACK;
          end else if (w == WAIT_SEEN) enter(PH_SYNC);
        end
        PH_SYNC: begin
          w = await_level(cfg.sync_timeout, lvl, 1'b1);
          if (w == WAIT_EXPIRED) begin
            failed = 1'b1;
            err    = ST_SYNC;
          end else if (w == WAIT_SEEN) enter(PH_PULSE);
        end
        PH_PULSE: begin
          w = await_level(cfg.pulse_timeout, lvl, 1'b0);
          if (w == WAIT_EXPIRED) begin
            failed = 1'b1;
            err    = ST_DATA;
          end else if (w == WAIT_SEEN) begin
            // drop the first pulse, threshold the rest MSB first
            if (pulse_no != '0)
              frame = {frame[38:0], tick_cnt > 10'(cfg.bit_threshold)};
            pulse_no = pulse_no + 6'd1;
            if (pulse_no >= PULSE_COUNT) complete = 1'b1;
            else enter(PH_SYNC);
            tick_cnt = '0;
          end
        end
        default: enter(PH_IDLE);
      endcase

      r            = '0;
      r.drive_line = line;
      if (failed || complete) begin
        enter(PH_IDLE);
        r.done_res = 1'b1;
        if (failed) r.status = err;
        else begin
          hraw = frame[39:24];
          traw = frame[23:8];
          sum  = hraw[15:8] + hraw[7:0] + traw[15:8] + traw[7:0];
          r.status   = (sum == frame[7:0]) ? ST_OK : ST_CSUM;
          r.humidity = hraw[14:0];
          // sign and magnitude from the sensor
          r.temperature = traw[15] ? 16'd0 - {1'b0, traw[14:0]} : {1'b0, traw[14:0]};
        end
      end else begin
        r.drive_low = (phase == PH_DRIVE);
        r.busy_res  = (phase != PH_IDLE);
      end
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      // keep the log short when everything goes wrong
      if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got_v, logic [15:0] exp_v);
      if (got_v !== exp_v)
        report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got_v, exp_v));
    endtask

    task check_result(swh_result_t got);
      swh_result_t exp_r;
      if (expected_results.size() == 0) begin
        report("result word with no tick word waiting");
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("drive_low", got.drive_low, exp_r.drive_low);
      compare_field("drive_line", got.drive_line, exp_r.drive_line);
      compare_field("busy_res", got.busy_res, exp_r.busy_res);
      compare_field("done_res", got.done_res, exp_r.done_res);
      compare_field("status", got.status, exp_r.status);
      compare_field("temperature", got.temperature, exp_r.temperature);
      compare_field("humidity", got.humidity, exp_r.humidity);
      checked++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               start_req;
  logic [2:0]         line_select;
  logic [7:0]         line_levels;
  logic               out_valid;
  logic               out_stall;
  logic               drive_low;
  logic [2:0]         drive_line;
  logic               busy_res;
  logic               done_res;
  logic [2:0]         status;
  logic signed [15:0] temperature;
  logic [14:0]        humidity;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [9:0]         cfg_data;

  read_result_board sb;

  // Stimulus controls shared between processes
  bit          idle_on;
  bit          hold_go;
  int          gap_pct;
  logic [3:0]  cur_err_phase;
  int          cur_err_pulse;
  bit          cur_noisy;
  logic [39:0] cur_frame;
  int          last_key;
  int          target;

  single_wire_humidity_sensor_reader_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_req   (start_req),
    .line_select (line_select),
    .line_levels (line_levels),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_low   (drive_low),
    .drive_line  (drive_line),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .status      (status),
    .temperature (temperature),
    .humidity    (humidity),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one tick word, optionally after an idle burst, and hold it until taken
  task automatic push_tick(input logic go, input logic [2:0] sel, input logic [7:0] levels);
    if (idle_on && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    start_req   <= go;
    line_select <= sel;
    line_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(go, sel, levels);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain everything and let the pipeline settle before touching registers
  task automatic settle();
    pause_sender();
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(input int thr, input int spt, input int idle_to,
                             input int resp_to, input int ack_to, input int sync_to,
                             input int pulse_to);
    write_reg(REG_BIT_THRESHOLD, 10'(thr));
    write_reg(REG_START_PULSE_TICKS, 10'(spt));
    write_reg(REG_IDLE_TIMEOUT, 10'(idle_to));
    write_reg(REG_RESPONSE_TIMEOUT, 10'(resp_to));
    write_reg(REG_ACK_TIMEOUT, 10'(ack_to));
    write_reg(REG_SYNC_TIMEOUT, 10'(sync_to));
    write_reg(REG_PULSE_TIMEOUT, 10'(pulse_to));
    cfg_we <= 1'b0;
  endtask

  // Count (after increment) at which the sensor shows the awaited level
  function automatic int pick_target();
    int lim;
    int thr;
    int t;
    case (sb.phase)
      PH_WAIT_IDLE: lim = sb.cfg.idle_timeout;
      PH_RESPONSE:  lim = sb.cfg.response_timeout;
      PH_ACK:       lim = sb.cfg.ack_timeout;
      PH_SYNC:      lim = sb.cfg.sync_timeout;
      PH_PULSE:     lim = sb.cfg.pulse_timeout;
      default:      return 1;
    endcase
    lim = lim + 1;
    if (cur_err_phase == sb.phase &&
        ((sb.phase != PH_SYNC && sb.phase != PH_PULSE) || sb.pulse_no == cur_err_pulse))
      return NEVER_TICKS;
    if (sb.phase == PH_PULSE && sb.pulse_no != '0) begin
      thr = sb.cfg.bit_threshold;
      if (cur_frame[40 - sb.pulse_no]) t = thr + 1 + $urandom_range(0, 1);
      else if (thr == 0) t = 1;
      else t = $urandom_range(0, 1) ? thr : $urandom_range(1, thr);
      return (t > lim) ? lim : t;
    end
    if (lim < 20 && $urandom_range(0, 7) == 0) return lim;
    return $urandom_range(1, (lim < 4) ? lim : 4);
  endfunction

  // Sensor side: set the active line's level for the current phase unless the read is noisy, others random
  function automatic logic [7:0] line_word();
    logic [7:0] lv;
    logic       want;
    int         key;
    lv  = 8'($urandom);
    key = {sb.phase, sb.pulse_no};
    if (key != last_key) begin
      last_key = key;
      target   = pick_target();
    end
    if (cur_noisy || sb.phase == PH_IDLE || sb.phase == PH_DRIVE) return lv;
    want = (sb.phase == PH_ACK || sb.phase == PH_PULSE) ? 1'b0 : 1'b1;
    lv[sb.line] = (int'(sb.tick_cnt) + 1 >= target) ? want : ~want;
    return lv;
  endfunction

  // One whole read: up to three idle ticks, the start tick, then ticks until the read ends
  task automatic run_read(input logic [2:0] sel, input logic [3:0] err_ph, input int err_pn,
                          input bit noisy_rd, input logic [39:0] frm, input int hold_at,
                          input int drain_at);
    int n;
    cur_err_phase = err_ph;
    cur_err_pulse = err_pn;
    cur_noisy     = noisy_rd;
    cur_frame     = frm;
    gap_pct       = $urandom_range(0, 2) * 10;
    repeat ($urandom_range(0, 3)) push_tick(1'b0, 3'($urandom), 8'($urandom));
    push_tick(1'b1, sel, 8'($urandom));
    n = 0;
    while (sb.phase != PH_IDLE) begin
      if (n == hold_at) hold_go = 1'b1;
      if (n == drain_at) begin
        pause_sender();
        wait_drained();
      end
      // start requests while busy must be ignored
      push_tick($urandom_range(0, 9) == 0, 3'($urandom), line_word());
      n++;
    end
  endtask

  function automatic logic [39:0] rand_frame();
    logic [15:0] hum;
    logic [15:0] tmp;
    logic [7:0]  cs;
    hum = 16'($urandom);
    tmp = 16'($urandom);
    if ($urandom_range(0, 3) == 0) tmp[14:0] = 15'($urandom_range(0, 3));
    cs = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
    if ($urandom_range(0, 4) == 0) cs = cs ^ 8'($urandom_range(1, 255));
    return {hum, tmp, cs};
  endfunction

  task automatic random_read();
    logic [3:0] ph;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) run_read(3'($urandom), PH_IDLE, 0, 1'b0, rand_frame(), -1, -1);
    else if (pick == 6) run_read(3'($urandom), PH_IDLE, 0, 1'b1, rand_frame(), -1, -1);
    else begin
      case ($urandom_range(0, 4))
        0:       ph = PH_WAIT_IDLE;
        1:       ph = PH_RESPONSE;
        2:       ph = PH_ACK;
        3:       ph = PH_SYNC;
        default: ph = PH_PULSE;
      endcase
      run_read(3'($urandom), ph, $urandom_range(0, 40), 1'b0, rand_frame(), -1, -1);
    end
  endtask

  // Result side: check accepted words, stall in bursts, and hold off on request
  initial begin : receiver
    swh_result_t got;
    int          left;
    int          pct;
    int          cyc;
    left      = 0;
    pct       = 15;
    cyc       = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.drive_low   = drive_low;
        got.drive_line  = drive_line;
        got.busy_res    = busy_res;
        got.done_res    = done_res;
        got.status      = status;
        got.temperature = temperature;
        got.humidity    = humidity;
        sb.check_result(got);
      end
      cyc++;
      if (cyc % 50 == 0) pct = $urandom_range(0, 2) * 15;
      if (hold_go) begin
        hold_go = 1'b0;
        left    = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(1, 100) <= pct) begin
        left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // End the run when neither side moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int goal;
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    start_req     = 1'b0;
    line_select   = '0;
    line_levels   = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idle_on       = 1'b1;
    hold_go       = 1'b0;
    gap_pct       = 10;
    cur_err_phase = PH_IDLE;
    cur_err_pulse = 0;
    cur_noisy     = 1'b0;
    cur_frame     = '0;
    last_key      = -1;
    target        = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lowest settings: zero timeouts, zero start length, zero threshold
    load_config(0, 0, 0, 0, 0, 0, 0);
    push_tick(1'b0, 3'd7, 8'hFF);
    push_tick(1'b0, 3'd0, 8'h00);
    run_read(3'd7, PH_WAIT_IDLE, 0, 1'b0, '0, -1, -1);
    run_read(3'd0, PH_RESPONSE, 0, 1'b0, '0, -1, -1);
    run_read(3'd5, PH_ACK, 0, 1'b0, '0, -1, -1);
    run_read(3'd2, PH_SYNC, 0, 1'b0, '0, -1, -1);
    run_read(3'd6, PH_PULSE, 0, 1'b0, '0, -1, -1);
    run_read(3'd1, PH_IDLE, 0, 1'b0, '0, -1, -1);
    settle();

    // Small settings: directed frames (negative zero, bad checksum, all ones, all zeros), then random reads
    load_config(1, 1, 3, 3, 3, 2, 3);
    run_read(3'd4, PH_IDLE, 0, 1'b0, {16'h0000, 16'h8000, 8'h80}, -1, -1);
    run_read(3'd3, PH_IDLE, 0, 1'b0, {16'h0123, 16'h0456, 8'h00}, -1, -1);
    run_read(3'd7, PH_IDLE, 0, 1'b0, 40'hFF_FFFF_FFFF, 10, -1);
    run_read(3'd0, PH_IDLE, 0, 1'b0, 40'h00_0000_0000, -1, 40);
    goal = 500;
    while (sb.checked + sb.pending() < goal) random_read();
    settle();

    // Highest settings: the line never idles high, so the longest idle wait runs out
    load_config(255, 1023, 255, 255, 255, 255, 255);
    run_read(3'd6, PH_WAIT_IDLE, 0, 1'b0, '0, -1, -1);
    settle();

    // Random moderate settings
    load_config($urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(0, 5),
                $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
                $urandom_range(3, 6));
    goal = sb.checked + 150;
    while (sb.checked + sb.pending() < goal) random_read();
    settle();

    // Last stretch at full rate with no idling on either side
    idle_on = 1'b0;
    load_config(2, 2, 4, 4, 4, 4, 5);
    goal = sb.checked + 100;
    while (sb.checked + sb.pending() < goal) random_read();

    pause_sender();
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
